### hdl/apu_pkg.sv
// shared constants, types and helpers for the adam parameter update block
`default_nettype none
package apu_pkg;
  localparam int ELEMENT_COUNT_DEF = 4096;
  localparam int FRACTION_BITS_DEF = 16;
  localparam int BETA_BITS = 16;
  localparam int LR_BITS = 24;
  localparam int IDX_W = 12;
  localparam int DATA_W = 32;

  localparam logic [1:0] REG_BETA_ONE = 2'd0;
  localparam logic [1:0] REG_BETA_TWO = 2'd1;
  localparam logic [1:0] REG_LR = 2'd2;

  localparam logic [15:0] BETA_ONE_RST = 16'd58982;
  localparam logic [15:0] BETA_TWO_RST = 16'd65471;
  localparam logic [23:0] LR_RST = 24'd16777;
  localparam logic [16:0] POWER_ONE = 17'h10000;

  // divider request: numerator, denominator
  typedef struct packed {
    logic [63:0] num;
    logic [63:0] den;
  } div_req_t;

  // saturating left shift of a 64 bit value
  function automatic logic [63:0] shl_sat(input logic [63:0] x, input int s);
    logic [63:0] r;
    r = x << s;
    if (s != 0 && (r >> s) != x) r = '1;
    return r;
  endfunction
endpackage
`default_nettype wire

### hdl/apu_mul.sv
// shift-add multiplier, one multiplier bit per cycle
`default_nettype none
module apu_mul
  import apu_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [63:0] a,
  input  wire logic [31:0] b,
  output logic [95:0]      prod,
  output logic             done
);
  logic [95:0] acc;
  logic [95:0] mcand;
  logic [31:0] mplier;
  logic [5:0]  cnt;
  logic        busy;

  assign prod = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= '0;
        acc <= '0;
        mcand <= {32'd0, a};
        mplier <= b;
      end else if (busy) begin
        if (mplier[0]) acc <= acc + mcand;
        mcand <= mcand << 1;
        mplier <= mplier >> 1;
        cnt <= cnt + 6'd1;
        if (cnt == 6'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

### hdl/apu_div.sv
// restoring divider, one quotient bit per cycle
`default_nettype none
module apu_div
  import apu_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     start,
  input  wire div_req_t req,
  output logic [63:0]   quo,
  output logic          done
);
  logic [64:0] rem;
  logic [63:0] q;
  logic [63:0] d;
  logic [6:0]  cnt;
  logic        busy;
  logic [64:0] trial;

  assign quo = q;
  assign trial = {rem[63:0], q[63]} - {1'b0, d};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        rem <= '0;
        q <= req.num;
        d <= req.den;
        cnt <= '0;
      end else if (busy) begin
        if (!trial[64]) begin
          rem <= trial;
          q <= {q[62:0], 1'b1};
        end else begin
          rem <= {rem[63:0], q[63]};
          q <= {q[62:0], 1'b0};
        end
        cnt <= cnt + 7'd1;
        if (cnt == 7'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

### hdl/apu_sqrt.sv
// integer square root, one result bit per cycle
`default_nettype none
module apu_sqrt
  import apu_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [63:0] x,
  output logic [31:0]      root,
  output logic             done
);
  logic [63:0] xr;
  logic [33:0] rem;
  logic [31:0] r;
  logic [5:0]  cnt;
  logic        busy;
  logic [35:0] trial;
  logic [35:0] shifted;

  assign root = r;
  assign shifted = {rem, xr[63:62]};
  assign trial = shifted - {2'b00, r, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        xr <= x;
        rem <= '0;
        r <= '0;
        cnt <= '0;
      end else if (busy) begin
        xr <= xr << 2;
        if (!trial[35]) begin
          rem <= trial[33:0];
          r <= {r[30:0], 1'b1};
        end else begin
          rem <= shifted[33:0];
          r <= {r[30:0], 1'b0};
        end
        cnt <= cnt + 6'd1;
        if (cnt == 6'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

### hdl/adam_parameter_update.sv
// top level of the adam parameter update block
// One element at a time. An item runs through a sequencer that shares one
// bit-serial multiplier, one restoring divider and one bit-serial square root.
// Nine products, three quotients and one root make up one item; the next beat
// is taken only after the result has been taken, so a stalled result holds it
// back. After reset a clearing pass zeroes the moment memories before the first
// beat is taken; configuration writes are taken during it.
`default_nettype none
module adam_parameter_update
  import apu_pkg::*;
#(
  parameter int ELEMENT_COUNT = ELEMENT_COUNT_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [3:0]            paddr,
  input  wire logic [31:0]           pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [IDX_W-1:0]      element_index,
  input  wire logic signed [DATA_W-1:0] param_value,
  input  wire logic signed [DATA_W-1:0] grad_value,
  input  wire logic                  end_of_step,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [IDX_W-1:0]           result_index,
  output logic signed [DATA_W-1:0]   new_param
);
  localparam int AW = (ELEMENT_COUNT > 1) ? $clog2(ELEMENT_COUNT) : 1;

  localparam logic [4:0] S_CLEAR = 5'd0;
  localparam logic [4:0] S_IDLE = 5'd1;
  localparam logic [4:0] S_READ = 5'd2;
  localparam logic [4:0] S_M1 = 5'd3;
  localparam logic [4:0] S_M2 = 5'd4;
  localparam logic [4:0] S_G = 5'd5;
  localparam logic [4:0] S_V1 = 5'd6;
  localparam logic [4:0] S_V2 = 5'd7;
  localparam logic [4:0] S_C1 = 5'd8;
  localparam logic [4:0] S_C2 = 5'd9;
  localparam logic [4:0] S_DM = 5'd10;
  localparam logic [4:0] S_DV = 5'd11;
  localparam logic [4:0] S_SQ = 5'd12;
  localparam logic [4:0] S_DR = 5'd13;
  localparam logic [4:0] S_L1 = 5'd14;
  localparam logic [4:0] S_L2 = 5'd15;
  localparam logic [4:0] S_OUT = 5'd16;

  logic [15:0] beta_one, beta_two;
  logic [23:0] learning_rate;
  logic [16:0] beta_one_power, beta_two_power;
  logic [4:0]  state;
  logic        go;

  logic [31:0] m_mem [ELEMENT_COUNT];
  logic [31:0] v_mem [ELEMENT_COUNT];
  logic [AW:0] clr_cnt;
  logic [31:0] m_rd, v_rd;
  logic [AW-1:0] rd_addr, wr_addr;
  logic        in_rng_now;

  logic [IDX_W-1:0] idx;
  logic signed [31:0] p, g;
  logic eos, in_range;
  logic signed [31:0] m_new;
  logic [31:0] v_new, gsq;
  logic signed [63:0] macc;
  logic [63:0] vacc;
  logic [16:0] c1, c2;
  logic [63:0] mhat, vhat, ratio;
  logic [40:0] step;
  logic [63:0] lrhi;

  logic        mul_start, mul_done;
  logic [63:0] mul_a;
  logic [31:0] mul_b;
  logic [95:0] mul_p;
  logic        div_start, div_done;
  div_req_t    div_req;
  logic [63:0] div_q;
  logic        sq_start, sq_done;
  logic [31:0] sq_root;
  logic [63:0] sq_x;

  apu_mul u_mul (.clk, .rst, .start(mul_start), .a(mul_a), .b(mul_b), .prod(mul_p),
                 .done(mul_done));
  apu_div u_div (.clk, .rst, .start(div_start), .req(div_req), .quo(div_q),
                 .done(div_done));
  apu_sqrt u_sqrt (.clk, .rst, .start(sq_start), .x(sq_x), .root(sq_root), .done(sq_done));

  assign pready = 1'b1;
  always_comb begin
    case (paddr[3:2])
      REG_BETA_ONE: prdata = {16'd0, beta_one};
      REG_BETA_TWO: prdata = {16'd0, beta_two};
      REG_LR:       prdata = {8'd0, learning_rate};
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      beta_one <= BETA_ONE_RST;
      beta_two <= BETA_TWO_RST;
      learning_rate <= LR_RST;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_BETA_ONE: beta_one <= pwdata[15:0];
        REG_BETA_TWO: beta_two <= pwdata[15:0];
        REG_LR:       learning_rate <= pwdata[23:0];
        default:      ;
      endcase
    end
  end

  assign in_ready = (state == S_IDLE);
  assign go = in_valid && in_ready;
  assign out_valid = (state == S_OUT);
  assign result_index = idx;

  assign rd_addr = AW'(element_index);
  assign wr_addr = AW'(idx);
  assign in_rng_now = {20'd0, element_index} < 32'(ELEMENT_COUNT);

  // signed terms are fed to the unsigned multiplier as magnitudes
  logic [31:0] um_abs, ug_abs, mnew_abs;
  assign ug_abs = g[31] ? 32'(-g) : 32'(g);
  assign um_abs = m_rd[31] ? 32'(-m_rd) : m_rd;
  assign mnew_abs = m_new[31] ? 32'(-m_new) : 32'(m_new);

  always_comb begin
    mul_start = 1'b0;
    mul_a = '0;
    mul_b = '0;
    div_start = 1'b0;
    div_req = '0;
    sq_start = 1'b0;
    sq_x = shl_sat(vhat, FRACTION_BITS);
    case (state)
      S_READ: begin
        mul_start = 1'b1;
        mul_a = {32'd0, um_abs};
        mul_b = {16'd0, beta_one};
      end
      S_M1: if (mul_done) begin
        mul_start = 1'b1;
        mul_a = {32'd0, ug_abs};
        mul_b = 32'h10000 - {16'd0, beta_one};
      end
      S_M2: if (mul_done) begin
        mul_start = 1'b1;
        mul_a = {32'd0, ug_abs};
        mul_b = ug_abs;
      end
      S_G: if (mul_done) begin
        mul_start = 1'b1;
        mul_a = {32'd0, v_rd};
        mul_b = {16'd0, beta_two};
      end
      S_V1: if (mul_done) begin
        mul_start = 1'b1;
        mul_a = {32'd0, gsq};
        mul_b = 32'h10000 - {16'd0, beta_two};
      end
      S_V2: if (mul_done) begin
        mul_start = 1'b1;
        mul_a = {47'd0, beta_one_power};
        mul_b = {16'd0, beta_one};
      end
      S_C1: if (mul_done) begin
        mul_start = 1'b1;
        mul_a = {47'd0, beta_two_power};
        mul_b = {16'd0, beta_two};
      end
      S_C2: if (mul_done) begin
        div_start = 1'b1;
        div_req.num = {16'd0, mnew_abs, 16'd0};
        div_req.den = 64'h10000 - {47'd0, c1};
      end
      S_DM: if (div_done) begin
        div_start = 1'b1;
        div_req.num = {16'd0, v_new, 16'd0};
        div_req.den = 64'h10000 - {47'd0, c2};
      end
      // the root takes vhat straight from the divider
      S_DV: if (div_done) begin
        sq_start = 1'b1;
        sq_x = shl_sat(div_q, FRACTION_BITS);
      end
      S_SQ: if (sq_done) begin
        div_start = 1'b1;
        div_req.num = shl_sat(mhat, FRACTION_BITS);
        div_req.den = {32'd0, sq_root} + 64'd1;
      end
      S_DR: if (div_done) begin
        mul_start = 1'b1;
        mul_a = {40'd0, learning_rate};
        mul_b = div_q[63:32];
      end
      S_L1: if (mul_done) begin
        mul_start = 1'b1;
        mul_a = {40'd0, learning_rate};
        mul_b = ratio[31:0];
      end
      default: ;
    endcase
  end

  // signed contributions from magnitude products
  logic signed [63:0] prod_s;
  assign prod_s = 64'(mul_p);

  logic [63:0] stp;
  always_comb begin
    stp = (lrhi << 8) + (mul_p[63:0] >> LR_BITS);
    if (lrhi >= 64'h100_0000_0000 || stp > 64'h100_0000_0000) stp = 64'h100_0000_0000;
  end

  logic signed [63:0] mres;
  logic signed [63:0] fin;
  assign mres = macc >>> BETA_BITS;
  assign fin = m_new[31] ? (64'(p) + $signed({23'd0, step})) : (64'(p) - $signed({23'd0, step}));

  always_ff @(posedge clk) begin
    if (state == S_CLEAR) begin
      m_mem[clr_cnt[AW-1:0]] <= '0;
      v_mem[clr_cnt[AW-1:0]] <= '0;
    end else if (state == S_C1 && mul_done && in_range) begin
      m_mem[wr_addr] <= m_new;
      v_mem[wr_addr] <= v_new;
    end
    if (go) begin
      m_rd <= in_rng_now ? m_mem[rd_addr] : '0;
      v_rd <= in_rng_now ? v_mem[rd_addr] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_cnt <= '0;
      beta_one_power <= POWER_ONE;
      beta_two_power <= POWER_ONE;
    end else begin
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == (AW+1)'(ELEMENT_COUNT - 1)) state <= S_IDLE;
        end
        S_IDLE: if (go) begin
          idx <= element_index;
          p <= param_value;
          g <= grad_value;
          eos <= end_of_step;
          in_range <= in_rng_now;
          state <= S_READ;
        end
        S_READ: begin
          state <= S_M1;
        end
        S_M1: if (mul_done) begin
          macc <= m_rd[31] ? -prod_s : prod_s;
          state <= S_M2;
        end
        S_M2: if (mul_done) begin
          logic signed [63:0] t;
          t = macc + (g[31] ? -prod_s : prod_s);
          macc <= t;
          state <= S_G;
        end
        S_G: if (mul_done) begin
          if (mres > 64'sh7FFF_FFFF) m_new <= 32'h7FFF_FFFF;
          else if (mres < -64'sh8000_0000) m_new <= 32'h8000_0000;
          else m_new <= mres[31:0];
          gsq <= ((mul_p[63:0] >> FRACTION_BITS) > 64'hFFFF_FFFF) ? '1
                 : 32'(mul_p[63:0] >> FRACTION_BITS);
          state <= S_V1;
        end
        S_V1: if (mul_done) begin
          vacc <= mul_p[63:0];
          state <= S_V2;
        end
        S_V2: if (mul_done) begin
          logic [63:0] t2;
          t2 = (vacc + mul_p[63:0]) >> BETA_BITS;
          v_new <= (t2 > 64'hFFFF_FFFF) ? '1 : t2[31:0];
          state <= S_C1;
        end
        S_C1: if (mul_done) begin
          c1 <= 17'(mul_p >> BETA_BITS);
          state <= S_C2;
        end
        S_C2: if (mul_done) begin
          c2 <= 17'(mul_p >> BETA_BITS);
          state <= S_DM;
        end
        S_DM: if (div_done) begin
          mhat <= div_q;
          state <= S_DV;
        end
        S_DV: if (div_done) begin
          vhat <= div_q;
          state <= S_SQ;
        end
        S_SQ: if (sq_done) begin
          state <= S_DR;
        end
        S_DR: if (div_done) begin
          ratio <= div_q;
          state <= S_L1;
        end
        S_L1: if (mul_done) begin
          lrhi <= mul_p[63:0];
          state <= S_L2;
        end
        S_L2: if (mul_done) begin
          step <= stp[40:0];
          state <= S_OUT;
          if (eos) begin
            beta_one_power <= c1;
            beta_two_power <= c2;
          end
        end
        S_OUT: if (out_ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    if (fin > 64'sh7FFF_FFFF) new_param = 32'h7FFF_FFFF;
    else if (fin < -64'sh8000_0000) new_param = 32'h8000_0000;
    else new_param = fin[31:0];
  end

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !in_ready) else $error("beat taken while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(new_param)))
    else $error("result dropped");
  a_power_le_one: assert property (@(posedge clk) disable iff (rst)
    (beta_one_power <= POWER_ONE) && (beta_two_power <= POWER_ONE))
    else $error("power above one");
endmodule
`default_nettype wire

### tb/tb_adam_parameter_update.sv
// self-checking testbench for the adam parameter update block
`timescale 1ns / 100ps
module tb_adam_parameter_update;
  import apu_pkg::*;

  localparam int STALL_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 1200;

  typedef struct {
    logic [IDX_W-1:0] idx;
    logic signed [DATA_W-1:0] p;
    logic signed [DATA_W-1:0] g;
    logic eos;
  } elem_t;

  typedef struct {
    logic [IDX_W-1:0] idx;
    logic signed [DATA_W-1:0] value;
  } update_t;

  logic clk, rst;
  logic psel, penable, pwrite;
  logic [3:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;
  logic in_valid, in_ready;
  logic [IDX_W-1:0] element_index;
  logic signed [DATA_W-1:0] param_value, grad_value;
  logic end_of_step;
  logic out_valid, out_ready;
  logic [IDX_W-1:0] result_index;
  logic signed [DATA_W-1:0] new_param;

  adam_parameter_update i_dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready),
    .element_index(element_index), .param_value(param_value),
    .grad_value(grad_value), .end_of_step(end_of_step),
    .out_valid(out_valid), .out_ready(out_ready),
    .result_index(result_index), .new_param(new_param)
  );

  // shadow of the block's registers and state
  logic [15:0] b1_reg, b2_reg;
  logic [23:0] lr_reg;
  logic [16:0] b1_pow, b2_pow;
  logic signed [31:0] mom1 [0:ELEMENT_COUNT_DEF-1];
  logic [31:0] mom2 [0:ELEMENT_COUNT_DEF-1];

  elem_t pend_elems[$];
  update_t expected_updates[$];
  int errors = 0;
  int stall_cnt = 0;
  bit idle_en = 1;
  bit in_taken = 0;
  int in_gap = 0;
  int out_gap = 0;
  logic [IDX_W-1:0] hot_idx [0:7];

  function automatic logic [63:0] shl16_sat(input logic [63:0] x);
    if ((x >> 48) != 0) return '1;
    return x << 16;
  endfunction

  function automatic logic [63:0] int_sqrt(input logic [63:0] x);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic void predict_update(input elem_t it);
    longint signed m, res, st;
    logic [63:0] v, ug, gsq, um, mhat, vhat, den, ratio, lo, hi, step, c1, c2;
    update_t u;
    m = longint'(mom1[it.idx]);
    v = {32'd0, mom2[it.idx]};
    m = (longint'(b1_reg) * m + longint'(65536 - int'(b1_reg)) * longint'(it.g)) >>> 16;
    if (m > 64'sd2147483647) m = 64'sd2147483647;
    if (m < -64'sd2147483648) m = -64'sd2147483648;
    ug = (it.g < 0) ? -longint'(it.g) : longint'(it.g);
    gsq = (ug * ug) >> 16;
    if (gsq > 64'hFFFF_FFFF) gsq = 64'hFFFF_FFFF;
    v = (64'(b2_reg) * v + 64'(65536 - int'(b2_reg)) * gsq) >> 16;
    if (v > 64'hFFFF_FFFF) v = 64'hFFFF_FFFF;
    mom1[it.idx] = m[31:0];
    mom2[it.idx] = v[31:0];
    // bias correction uses b^t, the stored power times beta
    c1 = (64'(b1_pow) * 64'(b1_reg)) >> 16;
    c2 = (64'(b2_pow) * 64'(b2_reg)) >> 16;
    um = (m < 0) ? -m : m;
    mhat = (um << 16) / (64'd65536 - c1);
    vhat = (v << 16) / (64'd65536 - c2);
    den = int_sqrt(shl16_sat(vhat)) + 1;
    ratio = shl16_sat(mhat) / den;
    lo = ratio & 64'hFFFF_FFFF;
    hi = ratio >> 32;
    if (64'(lr_reg) * hi >= (64'd1 << 40)) step = 64'd1 << 40;
    else step = ((64'(lr_reg) * hi) << 8) + ((64'(lr_reg) * lo) >> 24);
    if (step > (64'd1 << 40)) step = 64'd1 << 40;
    st = step;
    res = (m < 0) ? longint'(it.p) + st : longint'(it.p) - st;
    if (res > 64'sd2147483647) res = 64'sd2147483647;
    if (res < -64'sd2147483648) res = -64'sd2147483648;
    if (it.eos) begin
      b1_pow = c1[16:0];
      b2_pow = c2[16:0];
    end
    u.idx = it.idx;
    u.value = res[31:0];
    expected_updates.push_back(u);
  endfunction

  function automatic logic signed [31:0] rand_q16(input bit full_ok);
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 5) return $signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000;
    if (sel < 7) return $signed($urandom_range(0, 32'h0FFF_FFFF)) - 32'sh0800_0000;
    if (sel == 7 && full_ok) return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
    return $signed($urandom());
  endfunction

  function automatic elem_t rand_elem();
    elem_t e;
    e.idx = ($urandom_range(0, 9) < 7) ? hot_idx[$urandom_range(0, 7)]
                                       : IDX_W'($urandom_range(0, 4095));
    e.p = rand_q16(1);
    e.g = rand_q16(1);
    e.eos = ($urandom_range(0, 11) == 0);
    return e;
  endfunction

  function automatic elem_t mk(input int i, input int p, input int g, input bit eos);
    elem_t e;
    e.idx = IDX_W'(i);
    e.p = p;
    e.g = g;
    e.eos = eos;
    return e;
  endfunction

  task automatic reg_write(input logic [1:0] r, input logic [31:0] val);
    @(negedge clk);
    psel = 1;
    pwrite = 1;
    penable = 0;
    paddr = {r, 2'b00};
    pwdata = val;
    @(negedge clk);
    penable = 1;
    @(posedge clk);
    case (r)
      REG_BETA_ONE: b1_reg = val[15:0];
      REG_BETA_TWO: b2_reg = val[15:0];
      REG_LR: lr_reg = val[23:0];
      default: ;
    endcase
    @(negedge clk);
    psel = 0;
    penable = 0;
    pwrite = 0;
  endtask

  task automatic set_regs(input logic [15:0] b1, input logic [15:0] b2, input logic [23:0] lr);
    reg_write(REG_BETA_ONE, {16'd0, b1});
    reg_write(REG_BETA_TWO, {16'd0, b2});
    reg_write(REG_LR, {8'd0, lr});
  endtask

  task automatic drain();
    while (pend_elems.size() != 0 || in_valid || expected_updates.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // input driver
  always @(negedge clk) begin
    elem_t e;
    logic nv;
    if (rst) begin
      in_valid <= 0;
    end else if (!in_valid || in_taken) begin
      nv = 0;
      if (in_gap > 0) begin
        in_gap--;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        in_gap = $urandom_range(0, 13);
      end else if (pend_elems.size() != 0) begin
        e = pend_elems.pop_front();
        element_index <= e.idx;
        param_value <= e.p;
        grad_value <= e.g;
        end_of_step <= e.eos;
        nv = 1;
      end
      in_valid <= nv;
    end
    in_taken = 0;
  end

  // result side backpressure
  always @(negedge clk) begin
    logic rdy;
    rdy = 1;
    if (out_gap > 0) begin
      out_gap--;
      rdy = 0;
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      out_gap = $urandom_range(0, 13);
      rdy = 0;
    end
    out_ready <= rdy;
  end

  // monitor, scoreboard and watchdog
  always @(posedge clk) begin
    elem_t e;
    update_t u;
    if (!rst) begin
      stall_cnt++;
      if (in_valid && in_ready) begin
        e.idx = element_index;
        e.p = param_value;
        e.g = grad_value;
        e.eos = end_of_step;
        predict_update(e);
        in_taken = 1;
        stall_cnt = 0;
      end
      if (out_valid && out_ready) begin
        stall_cnt = 0;
        if (expected_updates.size() == 0) begin
          $error("unexpected beat: result_index=%0d new_param=%0d", result_index, new_param);
          errors++;
        end else begin
          u = expected_updates.pop_front();
          if (result_index !== u.idx) begin
            $error("result_index: expected %0d, got %0d", u.idx, result_index);
            errors++;
          end
          if (new_param !== u.value) begin
            $error("new_param: expected %0d, got %0d", u.value, new_param);
            errors++;
          end
        end
      end
      if (stall_cnt >= STALL_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    rst = 1;
    psel = 0;
    penable = 0;
    pwrite = 0;
    paddr = 0;
    pwdata = 0;
    in_valid = 0;
    out_ready = 0;
    element_index = 0;
    param_value = 0;
    grad_value = 0;
    end_of_step = 0;
    b1_reg = BETA_ONE_RST;
    b2_reg = BETA_TWO_RST;
    lr_reg = LR_RST;
    b1_pow = POWER_ONE;
    b2_pow = POWER_ONE;
    for (int i = 0; i < ELEMENT_COUNT_DEF; i++) begin
      mom1[i] = 0;
      mom2[i] = 0;
    end
    for (int i = 0; i < 8; i++) hot_idx[i] = IDX_W'($urandom_range(0, 4095));
    hot_idx[0] = 0;
    hot_idx[1] = 12'hFFF;
    repeat (3) @(posedge clk);
    rst <= 0;

    // directed: defaults, extremes of each field, step advance
    pend_elems.push_back(mk(0, 0, 0, 0));
    pend_elems.push_back(mk(4095, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0));
    pend_elems.push_back(mk(4095, 32'h8000_0000, 32'h8000_0000, 0));
    pend_elems.push_back(mk(1, 32'h8000_0000, 32'h7FFF_FFFF, 0));
    pend_elems.push_back(mk(2, 32'h7FFF_FFFF, 32'h8000_0000, 0));
    pend_elems.push_back(mk(3, 32'h0001_0000, 32'h0000_0001, 0));
    pend_elems.push_back(mk(3, 32'hFFFF_0000, 32'hFFFF_FFFF, 1));
    pend_elems.push_back(mk(3, 32'h0001_0000, 32'h0000_8000, 0));
    pend_elems.push_back(mk(4, 32'h5555_5555, 32'hAAAA_AAAA, 0));
    pend_elems.push_back(mk(4, 32'hAAAA_AAAA, 32'h5555_5555, 1));
    pend_elems.push_back(mk(2048, 0, 32'h0100_0000, 1));
    pend_elems.push_back(mk(2048, 0, 32'hFF00_0000, 1));
    pend_elems.push_back(mk(0, 32'h7FFF_FFFF, 0, 0));
    drain();

    // extremes: no decay memory, largest step size
    set_regs(16'd0, 16'd0, 24'hFF_FFFF);
    pend_elems.push_back(mk(5, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1));
    pend_elems.push_back(mk(5, 32'h8000_0000, 32'h8000_0000, 0));
    pend_elems.push_back(mk(6, 32'h8000_0000, 32'h0000_0001, 0));
    for (int i = 0; i < 140; i++) pend_elems.push_back(rand_elem());
    drain();

    // extremes: slowest decay, zero step size
    set_regs(16'hFFFF, 16'hFFFF, 24'd0);
    for (int i = 0; i < 140; i++) pend_elems.push_back(rand_elem());
    drain();

    set_regs(16'hFFFF, 16'd0, 24'd1);
    for (int i = 0; i < 140; i++) pend_elems.push_back(rand_elem());
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      set_regs(16'($urandom()), 16'($urandom()), 24'($urandom()));
      if (ph == 2) idle_en = 0;
      for (int i = 0; i < 140; i++) pend_elems.push_back(rand_elem());
      drain();
    end

    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
